[rtl/max_subarray_segment_tree_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the max-subarray segment tree
// Shared property wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MAX_SUBARRAY_SEGMENT_TREE_TOP_MACROS_SVH
`define MAX_SUBARRAY_SEGMENT_TREE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mst_pkg.sv]
// ----------------------------------------------------------------------------
// mst_pkg
// Types, constants and command codes shared by the segment tree modules.
// ----------------------------------------------------------------------------
package mst_pkg;

  localparam int unsigned LVL       = 10;
  localparam int unsigned LEAVES    = 1 << LVL;
  localparam int unsigned NODES     = 2 * LEAVES - 1;
  localparam int unsigned AW        = $clog2(NODES);
  localparam int unsigned DW        = $clog2(LVL + 1);
  localparam int unsigned POS_W     = 10;
  localparam int unsigned SUM_W     = 64;
  localparam int unsigned REC_W     = 4 * SUM_W;
  localparam int unsigned IN_DATA_W = ((3 * POS_W + REC_W + 7) / 8) * 8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // First listed member lands in the highest bits, so best sits lowest.
  typedef struct packed {
    logic [SUM_W-1:0] total;
    logic [SUM_W-1:0] suffix;
    logic [SUM_W-1:0] prefix;
    logic [SUM_W-1:0] best;
  } rec_t;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD_Q,
    CMD_LOAD_W,
    CMD_CLEAR,
    CMD_WLEAF,
    CMD_UREAD,
    CMD_UMERGE,
    CMD_QREAD,
    CMD_DESCEND,
    CMD_RET_MEM,
    CMD_RET_ZERO,
    CMD_POP,
    CMD_GO_RIGHT,
    CMD_RET_ACC
  } dp_cmd_e;

  typedef struct packed {
    logic covered;
    logic is_leaf;
    logic go_left;
    logic go_right;
    logic at_root;
    logic phase_left;
    logic clear_last;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_W_LEAF,
    ST_W_RD,
    ST_W_MRG,
    ST_Q_RD,
    ST_Q_EVAL,
    ST_Q_POP,
    ST_Q_NEXT,
    ST_OUT
  } state_e;

endpackage

[rtl/mst_ctrl.sv]
// ----------------------------------------------------------------------------
// mst_ctrl
// Sequencer for clearing, leaf writes and the stack-based range query walk.
// ----------------------------------------------------------------------------
module mst_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  input  logic                 s_user_i,
  input  logic                 m_ready_i,
  input  mst_pkg::dp_status_t  status_i,
  output mst_pkg::dp_cmd_e     cmd_o,
  output logic                 s_ready_o,
  output logic                 m_valid_o
);
  import mst_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = CMD_NOP;
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o = CMD_CLEAR;
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          if (s_user_i == OP_QUERY) begin
            cmd_o   = CMD_LOAD_Q;
            state_d = ST_Q_RD;
          end else begin
            cmd_o   = CMD_LOAD_W;
            state_d = ST_W_LEAF;
          end
        end
      end
      ST_W_LEAF: begin
        cmd_o   = CMD_WLEAF;
        state_d = ST_W_RD;
      end
      ST_W_RD: begin
        cmd_o   = CMD_UREAD;
        state_d = ST_W_MRG;
      end
      ST_W_MRG: begin
        cmd_o   = CMD_UMERGE;
        state_d = status_i.at_root ? ST_IDLE : ST_W_RD;
      end
      ST_Q_RD: begin
        cmd_o   = CMD_QREAD;
        state_d = ST_Q_EVAL;
      end
      ST_Q_EVAL: begin
        priority if (status_i.covered) begin
          cmd_o   = CMD_RET_MEM;
          state_d = ST_Q_POP;
        end else if (status_i.is_leaf || !(status_i.go_left || status_i.go_right)) begin
          cmd_o   = CMD_RET_ZERO;
          state_d = ST_Q_POP;
        end else begin
          cmd_o   = CMD_DESCEND;
          state_d = ST_Q_RD;
        end
      end
      ST_Q_POP: begin
        if (status_i.at_root) begin
          state_d = ST_OUT;
        end else begin
          cmd_o   = CMD_POP;
          state_d = ST_Q_NEXT;
        end
      end
      ST_Q_NEXT: begin
        if (status_i.phase_left && status_i.go_right) begin
          cmd_o   = CMD_GO_RIGHT;
          state_d = ST_Q_RD;
        end else begin
          cmd_o   = CMD_RET_ACC;
          state_d = ST_Q_POP;
        end
      end
      ST_OUT: begin
        m_valid_o = 1'b1;
        if (m_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

endmodule

[rtl/mst_dp.sv]
// ----------------------------------------------------------------------------
// mst_dp
// Node memory, merge unit, query stack and node geometry for the tree.
// ----------------------------------------------------------------------------
module mst_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mst_pkg::dp_cmd_e                  cmd_i,
  input  logic [mst_pkg::IN_DATA_W-1:0]     s_data_i,
  output mst_pkg::dp_status_t               status_o,
  output mst_pkg::rec_t                     result_o
);
  import mst_pkg::*;

  function automatic logic [SUM_W-1:0] smax(input logic [SUM_W-1:0] a,
                                            input logic [SUM_W-1:0] b);
    return ($signed(a) >= $signed(b)) ? a : b;
  endfunction

  function automatic rec_t merge(input rec_t x, input rec_t y);
    rec_t r;
    r.prefix = smax(x.prefix, x.total + y.prefix);
    r.suffix = smax(y.suffix, y.total + x.suffix);
    r.total  = x.total + y.total;
    r.best   = smax(smax(x.best, y.best), x.suffix + y.prefix);
    return r;
  endfunction

  rec_t mem [NODES];
  rec_t rda_q, rdb_q;

  logic [POS_W-1:0] lo_q, hi_q;
  logic [AW-1:0]    p_q;
  logic [DW-1:0]    d_q;
  logic [AW-1:0]    clr_q;
  rec_t             rec_in_q;
  rec_t             ret_q;
  rec_t             acc_q  [LVL+1];
  logic             left_q [LVL+1];

  logic [POS_W-1:0] in_pos, in_lo, in_hi;
  rec_t             in_rec;
  assign in_pos = s_data_i[POS_W-1:0];
  assign in_lo  = s_data_i[2*POS_W-1:POS_W];
  assign in_hi  = s_data_i[3*POS_W-1:2*POS_W];
  assign in_rec = s_data_i[3*POS_W+REC_W-1:3*POS_W];

  // Geometry of the current node: offset within its level, shifted by span.
  logic [AW-1:0]    parent, lchild, rchild, off;
  logic [DW-1:0]    span, dm1;
  logic [POS_W-1:0] pl, pr, mid;
  assign parent = (p_q - AW'(1)) >> 1;
  assign lchild = {parent[AW-2:0], 1'b1};
  assign rchild = lchild + AW'(1);
  assign off    = p_q + AW'(1) - (AW'(1) << d_q);
  assign span   = DW'(LVL) - d_q;
  assign dm1    = d_q - DW'(1);
  assign pl     = POS_W'(off << span);
  assign pr     = pl | POS_W'((AW'(1) << span) - AW'(1));
  assign mid    = pl | POS_W'((AW'(1) << (span - DW'(1))) - AW'(1));

  assign status_o.covered    = (lo_q <= pl) && (pr <= hi_q);
  assign status_o.is_leaf    = (d_q == DW'(LVL));
  assign status_o.go_left    = (lo_q <= mid);
  assign status_o.go_right   = (hi_q > mid);
  assign status_o.at_root    = (p_q == '0);
  assign status_o.phase_left = left_q[d_q];
  assign status_o.clear_last = (clr_q == AW'(NODES - 1));

  assign result_o = ret_q;

  // Node memory: one write port, two registered read ports.
  logic          we;
  logic [AW-1:0] wa, ra, rb;
  rec_t          wd;
  always_comb begin
    we = 1'b0;
    wa = p_q;
    wd = rec_in_q;
    ra = p_q;
    rb = rchild;
    unique case (cmd_i)
      CMD_CLEAR: begin
        we = 1'b1;
        wa = clr_q;
        wd = '0;
      end
      CMD_WLEAF:  we = 1'b1;
      CMD_UMERGE: begin
        we = 1'b1;
        wd = merge(rda_q, rdb_q);
      end
      CMD_UREAD:  ra = lchild;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rda_q <= mem[ra];
    rdb_q <= mem[rb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i == CMD_CLEAR) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LOAD_Q: begin
        lo_q <= in_lo;
        hi_q <= in_hi;
        p_q  <= '0;
        d_q  <= '0;
      end
      CMD_LOAD_W: begin
        rec_in_q <= in_rec;
        p_q      <= AW'(in_pos) + AW'(LEAVES - 1);
      end
      CMD_UREAD: p_q <= parent;
      CMD_DESCEND: begin
        acc_q[d_q]  <= '0;
        left_q[d_q] <= status_o.go_left;
        p_q         <= status_o.go_left ? {p_q[AW-2:0], 1'b1} : {p_q[AW-2:0], 1'b0} + AW'(2);
        d_q         <= d_q + DW'(1);
      end
      CMD_GO_RIGHT: begin
        left_q[d_q] <= 1'b0;
        p_q         <= {p_q[AW-2:0], 1'b0} + AW'(2);
        d_q         <= d_q + DW'(1);
      end
      CMD_RET_MEM:  ret_q <= rda_q;
      CMD_RET_ZERO: ret_q <= '0;
      CMD_RET_ACC:  ret_q <= acc_q[d_q];
      CMD_POP: begin
        acc_q[dm1] <= merge(acc_q[dm1], ret_q);
        p_q        <= parent;
        d_q        <= dm1;
      end
      default: ;
    endcase
  end

endmodule

[rtl/max_subarray_segment_tree_top.sv]
// ----------------------------------------------------------------------------
// max_subarray_segment_tree_top
// Segment tree of max-subarray records with leaf writes and range queries.
// ----------------------------------------------------------------------------
// Requests arrive on the slave stream. tuser carries the opcode: a write
// stores a four-field record at one leaf and re-merges all its ancestors; a
// query returns the merged record of range_low..range_high on the master
// stream. Writes produce no response.
// After reset the block sweeps the 2047-entry node memory to zero, one node
// per cycle, and holds s_axis_tready_o low until the sweep is done.
// One request is handled at a time; tready is high only while idle.
// A write first stores the leaf, then for each ancestor level reads both
// children on the dual-port memory and merges and writes the parent.
// A query steps through each visited node with a memory read and a covered
// check, and through each return step with a merge into the parent's frame
// and then either the right child or a further return.
// The result stays on the master port until taken; a stalled receiver
// simply holds the block in its output state.
// ----------------------------------------------------------------------------
module max_subarray_segment_tree_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata, low to high: position, range_low, range_high, leaf_best,
  // leaf_prefix, leaf_suffix, leaf_total, zero padding
  input  logic [mst_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // tuser: opcode
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata, low to high: best, prefix, suffix, total
  output logic [mst_pkg::REC_W-1:0]         m_axis_tdata_o
);
  import mst_pkg::*;

  dp_cmd_e    cmd;
  dp_status_t status;
  rec_t       result;

  mst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_user_i  (s_axis_tuser_i),
    .m_ready_i (m_axis_tready_i),
    .status_i  (status),
    .cmd_o     (cmd),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o)
  );

  mst_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .s_data_i (s_axis_tdata_i),
    .status_o (status),
    .result_o (result)
  );

  assign m_axis_tdata_o = result;

endmodule

[rtl/mst_checker.sv]
// ----------------------------------------------------------------------------
// mst_assert
// Port-level checks of the segment tree handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`include "max_subarray_segment_tree_top_macros.svh"

module mst_assert (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic                              s_axis_tuser_i,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [mst_pkg::REC_W-1:0]         m_axis_tdata_o
);
  import mst_pkg::*;

  logic s_fire;
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;

  `MST_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")
  `MST_ASSERT_SAME(a_no_accept_busy, m_axis_tvalid_o, !s_axis_tready_o,
    "request accepted while a result is pending")
  `MST_ASSERT_NEXT(a_no_instant_result, s_fire, !m_axis_tvalid_o,
    "result appeared in the cycle after acceptance")
  `MST_ASSERT_NEXT(a_write_busy, s_fire && (s_axis_tuser_i == OP_WRITE),
    !s_axis_tready_o && !m_axis_tvalid_o, "write did not occupy the block")

endmodule

bind max_subarray_segment_tree_top mst_assert u_mst_assert (.*);

[verif/mst_checker.sv]
// ----------------------------------------------------------------------------
// mst_checker
// Watches both streams of the segment tree, keeps a shadow tree of records,
// predicts every query answer and compares it field by field.
// ----------------------------------------------------------------------------
module mst_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  input  logic [mst_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  input  logic                          s_axis_tuser_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  input  logic [mst_pkg::REC_W-1:0]     m_axis_tdata_i,
  output int                            fail_count_o,
  output int                            answers_pending_o
);
  import mst_pkg::*;

  rec_t shadow_tree [4*LEAVES];
  rec_t answer_q [$];

  function automatic logic signed [SUM_W-1:0] smax(logic signed [SUM_W-1:0] a,
                                                   logic signed [SUM_W-1:0] b);
    return (a >= b) ? a : b;
  endfunction

  function automatic rec_t combine(rec_t x, rec_t y);
    rec_t r;
    r.prefix = smax(x.prefix, x.total + y.prefix);
    r.suffix = smax(y.suffix, y.total + x.suffix);
    r.total  = x.total + y.total;
    r.best   = smax(smax(x.best, y.best), x.suffix + y.prefix);
    return r;
  endfunction

  function automatic rec_t range_answer(int unsigned lo, int unsigned hi, int unsigned p,
                                        int unsigned pl, int unsigned pr);
    rec_t acc;
    int unsigned mid;
    acc = '0;
    if (lo <= pl && pr <= hi) return shadow_tree[p];
    if (pl == pr) return acc;
    mid = (pl + pr) >> 1;
    if (lo <= mid) acc = combine(acc, range_answer(lo, hi, 2*p+1, pl, mid));
    if (hi > mid) acc = combine(acc, range_answer(lo, hi, 2*p+2, mid+1, pr));
    return acc;
  endfunction

  task automatic store_leaf(int unsigned pos, rec_t v);
    int unsigned p, pl, pr, mid;
    int unsigned path [$];
    p = 0; pl = 0; pr = LEAVES - 1;
    while (pl != pr) begin
      path.push_front(p);
      mid = (pl + pr) >> 1;
      if (pos <= mid) begin
        p = 2*p + 1; pr = mid;
      end else begin
        p = 2*p + 2; pl = mid + 1;
      end
    end
    shadow_tree[p] = v;
    foreach (path[i]) shadow_tree[path[i]] = combine(shadow_tree[2*path[i]+1],
                                                     shadow_tree[2*path[i]+2]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned pos, lo, hi;
    rec_t got, want;
    if (!rst_ni) begin
      foreach (shadow_tree[i]) shadow_tree[i] = '0;
      answer_q.delete();
      fail_count_o = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        pos = 32'(s_axis_tdata_i[POS_W-1:0]);
        lo  = 32'(s_axis_tdata_i[2*POS_W-1:POS_W]);
        hi  = 32'(s_axis_tdata_i[3*POS_W-1:2*POS_W]);
        if (s_axis_tuser_i == OP_WRITE) begin
          if (pos < LEAVES) store_leaf(pos, rec_t'(s_axis_tdata_i[3*POS_W +: REC_W]));
        end else begin
          answer_q.push_back(range_answer(lo, hi, 0, 0, LEAVES - 1));
        end
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = rec_t'(m_axis_tdata_i);
        if (answer_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected answer %h", got);
        end else begin
          want = answer_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("answer differs: best %h/%h prefix %h/%h suffix %h/%h total %h/%h",
                       want.best, got.best, want.prefix, got.prefix,
                       want.suffix, got.suffix, want.total, got.total);
          end
        end
      end
    end
    answers_pending_o = answer_q.size();
  end
endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the max-subarray segment tree: directed corner requests, then
// random writes and queries with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_top;
  import mst_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_valid = 1'b0;
  logic                 s_ready;
  logic [IN_DATA_W-1:0] s_data = '0;
  logic                 s_user = 1'b0;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [REC_W-1:0]     m_data;
  int                   fail_count, answers_pending;
  int                   idle_cycles = 0;
  int                   rx_wait = 0;
  bit                   stim_done = 1'b0;

  // The watchdog limit covers the clearing sweep after reset plus the longest
  // query with a stalled receiver, many times over.
  localparam int WATCHDOG_LIMIT = 20000;

  always #1 clk_i = ~clk_i;

  max_subarray_segment_tree_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data)
  );

  mst_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_i(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_i(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_i(m_data),
    .fail_count_o(fail_count), .answers_pending_o(answers_pending)
  );

  function automatic logic [SUM_W-1:0] rand_sum();
    case ($urandom_range(0, 5))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return {$urandom, $urandom};
      default: return SUM_W'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  // Sends one request, after a random gap, and waits for its acceptance.
  // Valid stays high after acceptance so that a request with no gap follows
  // back to back; it is dropped only when a gap comes.
  task automatic send_request(logic op, logic [POS_W-1:0] pos, logic [POS_W-1:0] lo,
                              logic [POS_W-1:0] hi, rec_t rec);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= IN_DATA_W'({rec, hi, lo, pos});
    do @(posedge clk_i); while (!s_ready);
  endtask

  task automatic write_leaf(logic [POS_W-1:0] pos, rec_t rec);
    send_request(OP_WRITE, pos, POS_W'($urandom), POS_W'($urandom), rec);
  endtask

  task automatic query_range(logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
    rec_t junk;
    junk = {rand_sum(), rand_sum(), rand_sum(), rand_sum()};
    send_request(OP_QUERY, POS_W'($urandom), lo, hi, junk);
  endtask

  function automatic rec_t rand_rec();
    return {rand_sum(), rand_sum(), rand_sum(), rand_sum()};
  endfunction

  // Receiver side: each result waits a random delay before being taken.
  always @(posedge clk_i) begin
    if (m_valid && m_ready) begin
      rx_wait <= $urandom_range(0, 5);
      m_ready <= 1'b0;
    end else if (m_valid && !m_ready) begin
      if (rx_wait == 0) m_ready <= 1'b1;
      else rx_wait <= rx_wait - 1;
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("max_subarray_segment_tree_top: mismatch");
      $finish;
    end
  end

  initial begin
    int lo, hi, base, span;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: extremes of every field, both operations, empty and
    // inverted ranges, and wrapping sums.
    query_range(10'd0, 10'd1023);
    write_leaf(10'd0, {64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff,
                       64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff});
    write_leaf(10'd1, {64'h7fff_ffff_ffff_ffff, 64'h0000_0000_0000_0001,
                       64'h7fff_ffff_ffff_ffff, 64'h0000_0000_0000_0001});
    write_leaf(10'd1023, {64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                          64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000});
    write_leaf(10'd512, '1);
    write_leaf(10'd511, rand_rec());
    query_range(10'd0, 10'd1023);
    query_range(10'd0, 10'd1);
    query_range(10'd1, 10'd1);
    query_range(10'd1023, 10'd1023);
    query_range(10'd1023, 10'd0);
    query_range(10'd600, 10'd3);
    query_range(10'd511, 10'd512);
    query_range(10'd1, 10'd1022);
    write_leaf(10'd0, '0);
    query_range(10'd0, 10'd0);

    // Random part: writes and queries mixed, ranges mostly short so that
    // partial coverage shows up at every tree level.
    repeat (735) begin
      if ($urandom_range(0, 1) == 0) begin
        write_leaf(($urandom_range(0, 3) == 0) ? POS_W'($urandom) :
                   POS_W'($urandom_range(0, 63)), rand_rec());
      end else begin
        case ($urandom_range(0, 4))
          0: begin lo = $urandom_range(0, 1023); hi = $urandom_range(0, 1023); end
          1: begin lo = $urandom_range(0, 1023); hi = lo; end
          default: begin
            base = $urandom_range(0, 63); span = $urandom_range(0, 40);
            lo = base; hi = (base + span > 1023) ? 1023 : base + span;
          end
        endcase
        query_range(POS_W'(lo), POS_W'(hi));
      end
    end
    s_valid <= 1'b0;

    while (answers_pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("max_subarray_segment_tree_top: match");
    else $display("max_subarray_segment_tree_top: mismatch");
    $finish;
  end
endmodule
